// ===== rtl/core/thop_pkg.sv =====
package thop_pkg;

   localparam logic [7:0] MinHeader = 8'd20;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   localparam logic [1:0] W_KIND = 2'd0;
   localparam logic [1:0] W_LEN  = 2'd1;
   localparam logic [1:0] W_BODY = 2'd2;
   localparam logic [1:0] W_STOP = 2'd3;

   localparam logic [7:0] OPT_EOL   = 8'd0;
   localparam logic [7:0] OPT_NOP   = 8'd1;
   localparam logic [7:0] OPT_MSS   = 8'd2;
   localparam logic [7:0] OPT_WS    = 8'd3;
   localparam logic [7:0] OPT_SACKP = 8'd4;
   localparam logic [7:0] OPT_TS    = 8'd8;

   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] sequence_number;
      logic [31:0] ack_number;
      logic [5:0]  header_bytes;
      logic [7:0]  tcp_flag_bits;
      logic [15:0] window_size;
      logic [3:0]  option_present;
      logic [15:0] max_segment_size;
      logic [7:0]  window_scale_shift;
      logic [16:0] payload_offset;
   } result_type;

endpackage

// ===== rtl/core/tcp_header_option_parser.sv =====
// tcp header and option parser
// req_ channel: one segment byte per word, header first; req_last_byte ends a
//   packet and req_start_offset is sampled with the first byte of a packet
// rsp_ channel: at most one result word per packet, given when the header
//   completes, when the data offset is below 20 bytes (status 2) or when the
//   packet ends before the header is complete (status 1); error words carry
//   zero in every other field
// bytes after the result are dropped until the byte marked last
// throughput: one byte per cycle while req_ready is high; each byte is decided by
//   the front parser, which holds the whole per-packet state
// path: a result reaches rsp_ through the parser output register, then
//   through a two-entry queue
// when the receiver stalls the queue fills and req_ready drops once it is
//   full and the parser register holds a word
// reset (synchronous, active high) empties the queue and returns the parser
//   to waiting for the first byte of a packet
module tcp_header_option_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_start_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [31:0] rsp_sequence_number,
   output logic [31:0] rsp_ack_number,
   output logic [5:0]  rsp_header_bytes,
   output logic [7:0]  rsp_tcp_flag_bits,
   output logic [15:0] rsp_window_size,
   output logic [3:0]  rsp_option_present,
   output logic [15:0] rsp_max_segment_size,
   output logic [7:0]  rsp_window_scale_shift,
   output logic [16:0] rsp_payload_offset
);

   logic                 mid_valid, mid_ready, mid_gate;
   thop_pkg::result_type mid_word, out_word;

   // front stalls only when its register holds a word the queue cannot take
   assign mid_gate = mid_ready || !mid_valid;

   thop_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_byte   (req_data_byte),
      .in_last   (req_last_byte),
      .in_offset (req_start_offset),
      .res_valid (mid_valid),
      .res_ready (mid_gate),
      .res_word  (mid_word)
   );

   thop_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (mid_valid),
      .wr_ready (mid_ready),
      .wr_word  (mid_word),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_word  (out_word)
   );

   assign rsp_status             = out_word.status;
   assign rsp_source_port        = out_word.source_port;
   assign rsp_dest_port          = out_word.dest_port;
   assign rsp_sequence_number    = out_word.sequence_number;
   assign rsp_ack_number         = out_word.ack_number;
   assign rsp_header_bytes       = out_word.header_bytes;
   assign rsp_tcp_flag_bits      = out_word.tcp_flag_bits;
   assign rsp_window_size        = out_word.window_size;
   assign rsp_option_present     = out_word.option_present;
   assign rsp_max_segment_size   = out_word.max_segment_size;
   assign rsp_window_scale_shift = out_word.window_scale_shift;
   assign rsp_payload_offset     = out_word.payload_offset;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != thop_pkg::ST_OK) |->
         (rsp_header_bytes == 6'd0 && rsp_payload_offset == 17'd0))
      else $error("error word carries data");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == thop_pkg::ST_OK) |->
         ({2'b00, rsp_header_bytes} >= thop_pkg::MinHeader))
      else $error("ok word with short header");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (mid_valid && !mid_ready) |=> mid_valid)
      else $error("front word dropped");

endmodule

// ===== rtl/core/thop_front.sv =====
module thop_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  logic [15:0]            in_offset,
   output logic                   res_valid,
   input  logic                   res_ready,
   output thop_pkg::result_type   res_word
);

   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [15:0] base_ff, base_in;
   logic [31:0] ports_ff, ports_in;
   logic [63:0] seqack_ff, seqack_in;
   logic [23:0] flw_ff, flw_in;
   logic [1:0]  walk_ff, walk_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  olen_ff, olen_in;
   logic [5:0]  seen_ff, seen_in;
   logic [3:0]  oflags_ff, oflags_in;
   logic [15:0] mss_ff, mss_in;
   logic [7:0]  ws_ff, ws_in;

   logic        fire;
   logic        emit;
   logic        active;
   logic [5:0]  p;
   logic [8:0]  wend;
   thop_pkg::result_type word;

   assign in_ready = res_ready;
   assign fire     = in_valid && in_ready;
   assign active   = phase_ff != thop_pkg::PH_DONE;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      hlen_in   = hlen_ff;
      base_in   = base_ff;
      ports_in  = ports_ff;
      seqack_in = seqack_ff;
      flw_in    = flw_ff;
      walk_in   = walk_ff;
      kind_in   = kind_ff;
      olen_in   = olen_ff;
      seen_in   = seen_ff;
      oflags_in = oflags_ff;
      mss_in    = mss_ff;
      ws_in     = ws_ff;
      emit      = 1'b0;
      word      = '0;
      wend      = '0;
      if (phase_ff == thop_pkg::PH_IDLE) begin
         pos_in = '0; hlen_in = '0; ports_in = '0; seqack_in = '0; flw_in = '0;
         walk_in = thop_pkg::W_KIND; kind_in = '0; olen_in = '0; seen_in = '0;
         oflags_in = '0; mss_in = '0; ws_in = '0;
         base_in = in_offset;
      end
      p = pos_in;
      if (active) begin
         if (p < 6'd4) ports_in = {ports_in[23:0], in_byte};
         else if (p < 6'd12) seqack_in = {seqack_in[55:0], in_byte};
         else if (p == 6'd12) hlen_in = {in_byte[7:4], 2'b00};
         else if (p < 6'd16) flw_in = {flw_in[15:0], in_byte};
         else if (p >= 6'd20) begin
            unique case (walk_in)
               thop_pkg::W_KIND: begin
                  if (in_byte == thop_pkg::OPT_EOL) walk_in = thop_pkg::W_STOP;
                  else if (in_byte == thop_pkg::OPT_NOP) walk_in = walk_in;
                  else if ({1'b0, p} + 7'd2 > {1'b0, hlen_in})
                     walk_in = thop_pkg::W_STOP;
                  else begin
                     kind_in = in_byte;
                     walk_in = thop_pkg::W_LEN;
                  end
               end
               thop_pkg::W_LEN: begin
                  olen_in = in_byte;
                  wend    = {3'b000, p} - 9'd1 + {1'b0, in_byte};
                  if (in_byte < 8'd2 || wend > {3'b000, hlen_in})
                     walk_in = thop_pkg::W_STOP;
                  else begin
                     if (kind_in == thop_pkg::OPT_MSS && in_byte == 8'd4) begin
                        oflags_in[0] = 1'b1; mss_in = '0;
                     end
                     if (kind_in == thop_pkg::OPT_WS && in_byte == 8'd3) begin
                        oflags_in[1] = 1'b1; ws_in = '0;
                     end
                     if (kind_in == thop_pkg::OPT_SACKP && in_byte == 8'd2)
                        oflags_in[2] = 1'b1;
                     if (kind_in == thop_pkg::OPT_TS && in_byte == 8'd10)
                        oflags_in[3] = 1'b1;
                     seen_in = '0;
                     walk_in = (in_byte == 8'd2) ? thop_pkg::W_KIND : thop_pkg::W_BODY;
                  end
               end
               thop_pkg::W_BODY: begin
                  if (kind_in == thop_pkg::OPT_MSS && olen_in == 8'd4)
                     mss_in = {mss_in[7:0], in_byte};
                  if (kind_in == thop_pkg::OPT_WS && olen_in == 8'd3)
                     ws_in = in_byte;
                  seen_in = seen_in + 6'd1;
                  if ({3'b000, seen_in} + 9'd2 >= {1'b0, olen_in})
                     walk_in = thop_pkg::W_KIND;
               end
               default: walk_in = walk_in;
            endcase
         end
         phase_in = thop_pkg::PH_HEADER;
         if (p == 6'd19 && {2'b00, hlen_in} < thop_pkg::MinHeader) begin
            emit = 1'b1;
            word.status = thop_pkg::ST_MALFORMED;
            phase_in = thop_pkg::PH_DONE;
         end else if (p >= 6'd19 && {1'b0, p} + 7'd1 >= {1'b0, hlen_in}) begin
            emit = 1'b1;
            word.status             = thop_pkg::ST_OK;
            word.source_port        = ports_in[31:16];
            word.dest_port          = ports_in[15:0];
            word.sequence_number    = seqack_in[63:32];
            word.ack_number         = seqack_in[31:0];
            word.header_bytes       = hlen_in;
            word.tcp_flag_bits      = flw_in[23:16];
            word.window_size        = flw_in[15:0];
            word.option_present     = oflags_in;
            word.max_segment_size   = mss_in;
            word.window_scale_shift = ws_in;
            word.payload_offset     = {1'b0, base_in} + {11'd0, hlen_in};
            phase_in = thop_pkg::PH_DONE;
         end else if (in_last) begin
            emit = 1'b1;
            word.status = thop_pkg::ST_TRUNCATED;
            phase_in = thop_pkg::PH_DONE;
         end else if (p < 6'd63) begin
            pos_in = p + 6'd1;
         end
      end
      if (in_last) phase_in = thop_pkg::PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= thop_pkg::PH_IDLE;
         res_valid <= 1'b0;
      end else begin
         if (res_ready) res_valid <= fire && emit;
         if (fire) phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pos_ff <= pos_in; hlen_ff <= hlen_in; base_ff <= base_in;
         ports_ff <= ports_in; seqack_ff <= seqack_in; flw_ff <= flw_in;
         walk_ff <= walk_in; kind_ff <= kind_in; olen_ff <= olen_in;
         seen_ff <= seen_in; oflags_ff <= oflags_in; mss_ff <= mss_in; ws_ff <= ws_in;
      end
      if (res_ready && fire && emit) res_word <= word;
   end

endmodule

// ===== rtl/core/thop_queue.sv =====
module thop_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  thop_pkg::result_type wr_word,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output thop_pkg::result_type rd_word
);

   thop_pkg::result_type mem_ff [thop_pkg::QueueDepth];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr_fire, rd_fire;

   assign wr_ready = cnt_ff != 2'(thop_pkg::QueueDepth);
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_word  = mem_ff[rp_ff];
   assign wr_fire  = wr_valid && wr_ready;
   assign rd_fire  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_fire) wp_ff <= ~wp_ff;
         if (rd_fire) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr_fire} - {1'b0, rd_fire};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) mem_ff[wp_ff] <= wr_word;
   end

endmodule

// ===== tb/sv/tcp_header_option_parser_tb.sv =====
`timescale 1ns / 1ps

module tcp_header_option_parser_tb;

   localparam int WatchdogLimit = 3000;
   localparam int RandomWords = 1700;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [15:0] offset;
      logic        typed;
      logic [1:0]  status;
   } dir_row_type;

   localparam int DirRows = 23;
   localparam dir_row_type DirTable [DirRows] = '{
      '{8'hff, 1'b0, 16'hffff, 1'b0, thop_pkg::ST_OK},
      '{8'h00, 1'b1, 16'h0000, 1'b1, thop_pkg::ST_TRUNCATED},
      '{8'h00, 1'b1, 16'h0000, 1'b1, thop_pkg::ST_TRUNCATED},
      '{8'h00, 1'b0, 16'h0000, 1'b0, thop_pkg::ST_OK},
      '{8'h00, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'h80, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'h00, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'h00, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'h00, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'h4f, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'h00, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'h00, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b0, 16'h1234, 1'b0, thop_pkg::ST_OK},
      '{8'hff, 1'b1, 16'h1234, 1'b1, thop_pkg::ST_MALFORMED}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic [15:0] req_start_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   thop_pkg::result_type got;

   thop_pkg::result_type expected_results [$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          words_sent = 0;
   logic        hold_off = 1'b0;

   // parser state mirror
   logic [1:0]  m_phase = thop_pkg::PH_IDLE;
   int unsigned m_pos, m_hlen, m_base, m_kind, m_olen, m_seen;
   logic [31:0] m_ports;
   logic [63:0] m_seqack;
   logic [23:0] m_flgwin;
   logic [1:0]  m_walk;
   logic [3:0]  m_oflags;
   logic [15:0] m_mss;
   logic [7:0]  m_ws;

   tcp_header_option_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .req_start_offset(req_start_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(got.status), .rsp_source_port(got.source_port),
      .rsp_dest_port(got.dest_port), .rsp_sequence_number(got.sequence_number),
      .rsp_ack_number(got.ack_number), .rsp_header_bytes(got.header_bytes),
      .rsp_tcp_flag_bits(got.tcp_flag_bits), .rsp_window_size(got.window_size),
      .rsp_option_present(got.option_present),
      .rsp_max_segment_size(got.max_segment_size),
      .rsp_window_scale_shift(got.window_scale_shift),
      .rsp_payload_offset(got.payload_offset)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void walk_option(input int unsigned b, input int unsigned p);
      case (m_walk)
         thop_pkg::W_KIND: begin
            if (b == thop_pkg::OPT_EOL) m_walk = thop_pkg::W_STOP;
            else if (b == thop_pkg::OPT_NOP) ;
            else if (p + 2 > m_hlen) m_walk = thop_pkg::W_STOP;
            else begin
               m_kind = b;
               m_walk = thop_pkg::W_LEN;
            end
         end
         thop_pkg::W_LEN: begin
            m_olen = b;
            if (b < 2 || (p - 1) + b > m_hlen) m_walk = thop_pkg::W_STOP;
            else begin
               if (m_kind == thop_pkg::OPT_MSS && b == 4) begin
                  m_oflags[0] = 1'b1; m_mss = '0;
               end
               if (m_kind == thop_pkg::OPT_WS && b == 3) begin
                  m_oflags[1] = 1'b1; m_ws = '0;
               end
               if (m_kind == thop_pkg::OPT_SACKP && b == 2) m_oflags[2] = 1'b1;
               if (m_kind == thop_pkg::OPT_TS && b == 10) m_oflags[3] = 1'b1;
               m_seen = 0;
               m_walk = (b == 2) ? thop_pkg::W_KIND : thop_pkg::W_BODY;
            end
         end
         thop_pkg::W_BODY: begin
            if (m_kind == thop_pkg::OPT_MSS && m_olen == 4) m_mss = {m_mss[7:0], b[7:0]};
            if (m_kind == thop_pkg::OPT_WS && m_olen == 3) m_ws = b[7:0];
            m_seen = (m_seen + 1) & 63;
            if (m_seen + 2 >= m_olen) m_walk = thop_pkg::W_KIND;
         end
         default: ;
      endcase
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     input logic [15:0] off,
                                     output thop_pkg::result_type r);
      int unsigned p;
      bit hit;
      hit = 1'b0;
      r = '0;
      if (m_phase == thop_pkg::PH_IDLE) begin
         m_pos = 0; m_hlen = 0; m_base = off; m_ports = '0; m_seqack = '0;
         m_flgwin = '0; m_walk = thop_pkg::W_KIND; m_kind = 0; m_olen = 0; m_seen = 0;
         m_oflags = '0; m_mss = '0; m_ws = '0;
         m_phase = thop_pkg::PH_HEADER;
      end
      if (m_phase == thop_pkg::PH_HEADER) begin
         p = m_pos;
         if (p < 4) m_ports = {m_ports[23:0], b};
         else if (p < 12) m_seqack = {m_seqack[55:0], b};
         else if (p == 12) m_hlen = b[7:4] * 4;
         else if (p < 16) m_flgwin = {m_flgwin[15:0], b};
         else if (p >= thop_pkg::MinHeader) walk_option(b, p);

         if (p == thop_pkg::MinHeader - 1 && m_hlen < thop_pkg::MinHeader) begin
            r.status = thop_pkg::ST_MALFORMED;
            hit = 1'b1;
         end else if (p >= thop_pkg::MinHeader - 1 && p + 1 >= m_hlen) begin
            r.status = thop_pkg::ST_OK;
            r.source_port = m_ports[31:16];
            r.dest_port = m_ports[15:0];
            r.sequence_number = m_seqack[63:32];
            r.ack_number = m_seqack[31:0];
            r.header_bytes = m_hlen[5:0];
            r.tcp_flag_bits = m_flgwin[23:16];
            r.window_size = m_flgwin[15:0];
            r.option_present = m_oflags;
            r.max_segment_size = m_mss;
            r.window_scale_shift = m_ws;
            r.payload_offset = 17'(m_base + m_hlen);
            hit = 1'b1;
         end else if (last) begin
            r.status = thop_pkg::ST_TRUNCATED;
            hit = 1'b1;
         end else if (m_pos < 63) m_pos++;
         if (hit) m_phase = thop_pkg::PH_DONE;
      end
      if (last) m_phase = thop_pkg::PH_IDLE;
      return hit;
   endfunction

   task automatic send(input logic [7:0] b, input logic last, input logic [15:0] off,
                       input bit typed, input logic [1:0] st);
      thop_pkg::result_type r;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      req_start_offset <= off;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (parse_byte(b, last, off, r)) begin
         if (typed) begin
            r = '0;
            r.status = st;
         end
         expected_results.push_back(r);
      end
   endtask

   task automatic send_segment();
      logic [7:0] seg [$];
      logic [15:0] off;
      int doff, hl, cut, k, n;
      seg = {};
      doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      hl = (doff < 5) ? 20 : doff * 4;
      for (k = 0; k < 12; k++) seg.push_back(8'($urandom_range(0, 255)));
      seg.push_back({doff[3:0], 4'($urandom_range(0, 15))});
      for (k = 13; k < 20; k++) seg.push_back(8'($urandom_range(0, 255)));
      while (seg.size() < hl) begin
         case ($urandom_range(0, 9))
            0: seg.push_back(thop_pkg::OPT_NOP);
            1: seg.push_back(thop_pkg::OPT_EOL);
            2: begin seg.push_back(thop_pkg::OPT_MSS); seg.push_back(8'd4);
                  seg.push_back(8'($urandom_range(0, 255)));
                  seg.push_back(8'($urandom_range(0, 255))); end
            3: begin seg.push_back(thop_pkg::OPT_WS); seg.push_back(8'd3);
                  seg.push_back(8'($urandom_range(0, 255))); end
            4: begin seg.push_back(thop_pkg::OPT_SACKP); seg.push_back(8'd2); end
            5: begin seg.push_back(thop_pkg::OPT_TS); seg.push_back(8'd10);
                  repeat (8) seg.push_back(8'($urandom_range(0, 255))); end
            6: begin
                  seg.push_back(8'($urandom_range(0, 255)));
                  n = $urandom_range(2, 6);
                  seg.push_back(8'(n));
                  repeat (n - 2) seg.push_back(8'($urandom_range(0, 255)));
               end
            7: begin
                  seg.push_back(8'($urandom_range(2, 8)));
                  seg.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                                             : 8'($urandom_range(2, 255)));
               end
            default: seg.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      while (seg.size() > hl) void'(seg.pop_back());
      repeat ($urandom_range(0, 4)) seg.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, seg.size());
         while (seg.size() > cut) void'(seg.pop_back());
      end
      case ($urandom_range(0, 9))
         0: off = 16'h0000;
         1: off = 16'hffff;
         default: off = 16'($urandom_range(0, 65535));
      endcase
      foreach (seg[i])
         send(seg[i], i == seg.size() - 1,
              (i == 0) ? off : 16'($urandom_range(0, 65535)), 1'b0, thop_pkg::ST_OK);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off) rsp_ready <= 1'b0;
      else if ((($time / 12) % 400) < 150) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) report("result word with none expected");
         else begin
            thop_pkg::result_type e;
            e = expected_results.pop_front();
            if (got.status !== e.status) report($sformatf("status %0d exp %0d", got.status, e.status));
            if (got.source_port !== e.source_port) report("source_port mismatch");
            if (got.dest_port !== e.dest_port) report("dest_port mismatch");
            if (got.sequence_number !== e.sequence_number) report("sequence_number mismatch");
            if (got.ack_number !== e.ack_number) report("ack_number mismatch");
            if (got.header_bytes !== e.header_bytes) report("header_bytes mismatch");
            if (got.tcp_flag_bits !== e.tcp_flag_bits) report("tcp_flag_bits mismatch");
            if (got.window_size !== e.window_size) report("window_size mismatch");
            if (got.option_present !== e.option_present) report("option_present mismatch");
            if (got.max_segment_size !== e.max_segment_size) report("max_segment_size mismatch");
            if (got.window_scale_shift !== e.window_scale_shift)
               report("window_scale_shift mismatch");
            if (got.payload_offset !== e.payload_offset) report("payload_offset mismatch");
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      bit held, drained;
      held = 1'b0;
      drained = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DirRows; i++)
         send(DirTable[i].data, DirTable[i].last, DirTable[i].offset,
              DirTable[i].typed, DirTable[i].status);
      while (words_sent < RandomWords + DirRows) begin
         if (!held && words_sent > 600) begin
            held = 1'b1;
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off <= 1'b0;
               end
            join_none
         end
         if (!drained && words_sent > 1200) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clock);
            repeat (3) @(posedge clock);
         end
         send_segment();
      end
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
